>>> hdl/assert_macros.svh
// Assertion macros used by the evaluator controller (bsde_ctrl).
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BSDE_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define BSDE_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> hdl/bsde_pkg.sv
// Shared types, constants and codes for the B-spline de Boor evaluator.
// No dependencies.
package bsde_pkg;
    localparam int MAX_DEGREE  = 5;
    localparam int KNOT_DEPTH  = 64;
    localparam int POINT_DEPTH = 64;

    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int FRAC_W = 16;
    localparam int DEG_W  = 3;
    localparam int ROW_W  = $clog2(MAX_DEGREE + 1);
    localparam int DEN_W  = VAL_W + 1;
    localparam int NUM_W  = VAL_W + 1 + FRAC_W;
    localparam int PROD_W = VAL_W + DEN_W;

    localparam logic [1:0] OP_WR_KNOT  = 2'd0;
    localparam logic [1:0] OP_WR_POINT = 2'd1;
    localparam logic [1:0] OP_EVAL     = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] curve_param;
        logic [IDX_W-1:0]        span_index;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] curve_value;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        logic             latch;
        logic             wr_knot;
        logic             wr_point;
        logic             pt_rd;
        logic             ka_rd;
        logic             kb_rd;
        logic             cap_ka;
        logic             cap_kb;
        logic             div_start;
        logic             mul;
        logic             row_wr;
        logic             row_wr_blend;
        logic             emit;
        logic [1:0]       emit_status;
        logic [ROW_W-1:0] row_addr;
        logic [ROW_W-1:0] i;
        logic [ROW_W-1:0] j;
        logic [ROW_W-1:0] r;
        logic [ROW_W-1:0] p;
    } t_dp_cmd;

    typedef struct packed {
        logic range_bad;
        logic den_zero;
        logic div_done;
    } t_dp_stat;
endpackage

>>> hdl/bspline_de_boor_evaluator.sv
// Write items are taken in the idle state; an evaluate item's result is accepted after
// the copy of the p+1 points (p = degree) and all blend steps.
// Each blend step is bound by the shared 49-step radix-2 alpha divider; one item at a time.
// A range or zero-denominator error returns sooner. The result strobe lasts one cycle.
// Synchronous active-low reset clears control state and sets the degree to 3;
// knot and point stores hold undefined data until written.
module bspline_de_boor_evaluator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bsde_pkg::t_in_item         i_item,
    output bsde_pkg::t_out_item        o_result,
    output logic                       o_result_valid,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bsde_pkg::DEG_W-1:0] i_cfg_data
);
    import bsde_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bsde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_item.operation),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cfg_ready (o_cfg_ready),
        .busy        (busy),
        .o_cmd       (cmd)
    );

    bsde_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );
endmodule

>>> hdl/bsde_div.sv
// Radix-2 restoring divider for alpha = (num * 2^16) / den, truncated, saturated.
// Depends on bsde_pkg.
module bsde_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [bsde_pkg::NUM_W-1:0] i_num,
    input  logic signed [bsde_pkg::DEN_W-1:0] i_den,
    output logic                             o_done,
    output logic signed [bsde_pkg::VAL_W-1:0] o_quot
);
    import bsde_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_nmag;
    logic [DEN_W-1:0] r_dmag;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_q;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_fin;
    logic             r_done;
    logic signed [VAL_W-1:0] r_quot;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   trial;
    logic [VAL_W-1:0] sat_q;

    assign rem_sh = {r_rem, r_nmag[NUM_W-1]};
    assign trial  = rem_sh - {1'b0, r_dmag};

    always_comb begin
        if (r_neg) begin
            if (r_q > NUM_W'(64'h8000_0000)) begin
                sat_q = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                sat_q = -r_q[VAL_W-1:0];
            end
        end else begin
            if (r_q > NUM_W'(64'h7FFF_FFFF)) begin
                sat_q = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                sat_q = r_q[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nmag <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_dmag <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            r_neg  <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_nmag <= {r_nmag[NUM_W-2:0], 1'b0};
            if (!trial[DEN_W]) begin
                r_rem <= trial[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
        if (r_fin) begin
            r_quot <= sat_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> hdl/bsde_datapath.sv
// Datapath: knot, point and work-row stores, divider, blend multiplier, result register.
// Depends on bsde_pkg and bsde_div.
module bsde_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsde_pkg::t_in_item   i_item,
    input  bsde_pkg::t_dp_cmd    i_cmd,
    output bsde_pkg::t_dp_stat   o_stat,
    output bsde_pkg::t_out_item  o_result,
    output logic                 o_result_valid
);
    import bsde_pkg::*;

    logic signed [VAL_W-1:0] knot_mem  [KNOT_DEPTH];
    logic signed [VAL_W-1:0] point_mem [POINT_DEPTH];
    logic signed [VAL_W-1:0] row_mem   [MAX_DEGREE+1];

    logic signed [VAL_W-1:0]  r_t;
    logic [IDX_W-1:0]         r_k;
    logic signed [VAL_W-1:0]  r_krd;
    logic signed [VAL_W-1:0]  r_prd;
    logic signed [VAL_W-1:0]  r_rowq;
    logic signed [VAL_W-1:0]  r_ka;
    logic signed [VAL_W-1:0]  r_kb;
    logic signed [VAL_W-1:0]  r_rj;
    logic signed [VAL_W-1:0]  r_rjm1;
    logic signed [PROD_W-1:0] r_prod;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic [IDX_W-1:0]         kbase;
    logic [IDX_W-1:0]         ka_addr;
    logic [IDX_W-1:0]         kb_addr;
    logic [IDX_W-1:0]         pt_addr;
    logic signed [DEN_W-1:0]  den;
    logic signed [DEN_W-1:0]  num;
    logic signed [DEN_W-1:0]  diff;
    logic signed [PROD_W-1:0] blend_sum;
    logic signed [VAL_W-1:0]  blend_sat;
    logic signed [VAL_W-1:0]  row_wdata;
    logic                     div_done;
    logic signed [VAL_W-1:0]  alpha;
    logic [IDX_W:0]           k_plus_p;

    assign kbase   = r_k - IDX_W'(i_cmd.p);
    assign ka_addr = kbase + IDX_W'(i_cmd.j);
    assign kb_addr = r_k + IDX_W'(i_cmd.j) + IDX_W'(1) - IDX_W'(i_cmd.r);
    assign pt_addr = kbase + IDX_W'(i_cmd.i);

    assign den  = DEN_W'(r_kb) - DEN_W'(r_ka);
    assign num  = DEN_W'(r_t) - DEN_W'(r_ka);
    assign diff = DEN_W'(r_rj) - DEN_W'(r_rjm1);

    assign k_plus_p = {1'b0, r_k} + (IDX_W+1)'(i_cmd.p);

    assign o_stat.range_bad = ({1'b0, r_k} < (IDX_W+1)'(i_cmd.p))
                           || (32'(r_k) >= POINT_DEPTH)
                           || (32'(k_plus_p) >= KNOT_DEPTH);
    assign o_stat.den_zero  = (den == '0);
    assign o_stat.div_done  = div_done;

    // floor divide by 2^16 is an arithmetic shift
    assign blend_sum = PROD_W'(r_rjm1) + (r_prod >>> FRAC_W);

    always_comb begin
        if (blend_sum > PROD_W'(64'sh7FFF_FFFF)) begin
            blend_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (blend_sum < -PROD_W'(64'sh8000_0000)) begin
            blend_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            blend_sat = blend_sum[VAL_W-1:0];
        end
    end

    assign row_wdata = i_cmd.row_wr_blend ? blend_sat : r_prd;

    bsde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({num, {FRAC_W{1'b0}}}),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (alpha)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_knot && (32'(i_item.entry_index) < KNOT_DEPTH)) begin
            knot_mem[i_item.entry_index] <= i_item.entry_value;
        end
        if (i_cmd.ka_rd) begin
            r_krd <= knot_mem[ka_addr];
        end else if (i_cmd.kb_rd) begin
            r_krd <= knot_mem[kb_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_point && (32'(i_item.entry_index) < POINT_DEPTH)) begin
            point_mem[i_item.entry_index] <= i_item.entry_value;
        end
        if (i_cmd.pt_rd) begin
            r_prd <= point_mem[pt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            row_mem[i_cmd.row_addr] <= row_wdata;
        end
        r_rowq <= row_mem[i_cmd.row_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_t <= i_item.curve_param;
            r_k <= i_item.span_index;
        end
        if (i_cmd.cap_ka) begin
            r_ka <= r_krd;
            r_rj <= r_rowq;
        end
        if (i_cmd.cap_kb) begin
            r_kb   <= r_krd;
            r_rjm1 <= r_rowq;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(alpha) * PROD_W'(diff);
        end
        if (i_cmd.emit) begin
            r_out.status      <= i_cmd.emit_status;
            r_out.curve_value <= (i_cmd.emit_status == ST_OK) ? r_rowq : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;
endmodule

>>> hdl/bsde_ctrl.sv
// Controller: degree register, accept logic and the de Boor step sequencer.
// Depends on bsde_pkg and assert_macros.svh.
module bsde_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [1:0]                 i_operation,
    input  logic                       i_cfg_valid,
    input  logic [bsde_pkg::DEG_W-1:0] i_cfg_data,
    input  bsde_pkg::t_dp_stat         i_stat,
    output logic                       o_cfg_ready,
    output logic                       busy,
    output bsde_pkg::t_dp_cmd          o_cmd
);
    import bsde_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_CP_RD = 4'd2;
    localparam logic [3:0] S_CP_WR = 4'd3;
    localparam logic [3:0] S_KA    = 4'd4;
    localparam logic [3:0] S_KB    = 4'd5;
    localparam logic [3:0] S_DEN   = 4'd6;
    localparam logic [3:0] S_DCHK  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_BLEND = 4'd10;
    localparam logic [3:0] S_FRD   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0]       r_state, n_state;
    logic [DEG_W-1:0] r_deg;
    logic [ROW_W-1:0] r_i, n_i;
    logic [ROW_W-1:0] r_j, n_j;
    logic [ROW_W-1:0] r_r, n_r;
    logic [1:0]       r_status, n_status;
    logic [ROW_W-1:0] p_eff;
    logic             idle;

    assign p_eff = (32'(r_deg) > MAX_DEGREE) ? ROW_W'(MAX_DEGREE) : ROW_W'(r_deg);
    assign idle        = (r_state == S_IDLE);
    assign busy        = !idle;
    assign o_cfg_ready = idle;

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_r      = r_r;
        n_status = r_status;

        o_cmd              = '0;
        o_cmd.i            = r_i;
        o_cmd.j            = r_j;
        o_cmd.r            = r_r;
        o_cmd.p            = p_eff;
        o_cmd.emit_status  = r_status;
        o_cmd.row_addr     = r_j;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.wr_knot  = (i_operation == OP_WR_KNOT);
                    o_cmd.wr_point = (i_operation == OP_WR_POINT);
                    if (i_operation == OP_EVAL) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_i = '0;
                if (i_stat.range_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_EMIT;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_CP_RD;
                end
            end
            S_CP_RD: begin
                o_cmd.pt_rd = 1'b1;
                n_state     = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd.row_wr   = 1'b1;
                o_cmd.row_addr = r_i;
                if (r_i == p_eff) begin
                    n_r     = ROW_W'(1);
                    n_j     = p_eff;
                    n_state = (p_eff == '0) ? S_FRD : S_KA;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CP_RD;
                end
            end
            S_KA: begin
                o_cmd.ka_rd = 1'b1;
                n_state     = S_KB;
            end
            S_KB: begin
                o_cmd.cap_ka   = 1'b1;
                o_cmd.kb_rd    = 1'b1;
                o_cmd.row_addr = r_j - 1'b1;
                n_state        = S_DEN;
            end
            S_DEN: begin
                o_cmd.cap_kb = 1'b1;
                n_state      = S_DCHK;
            end
            S_DCHK: begin
                if (i_stat.den_zero) begin
                    n_status = ST_ZERO_DEN;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.row_wr       = 1'b1;
                o_cmd.row_wr_blend = 1'b1;
                if (r_j == r_r) begin
                    if (r_r == p_eff) begin
                        n_state = S_FRD;
                    end else begin
                        n_r     = r_r + 1'b1;
                        n_j     = p_eff;
                        n_state = S_KA;
                    end
                end else begin
                    n_j     = r_j - 1'b1;
                    n_state = S_KA;
                end
            end
            S_FRD: begin
                o_cmd.row_addr = p_eff;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_deg    <= DEGREE_RESET;
            r_i      <= '0;
            r_j      <= '0;
            r_r      <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_i      <= n_i;
            r_j      <= n_j;
            r_r      <= n_r;
            r_status <= n_status;
            if (i_cfg_valid && o_cfg_ready) begin
                r_deg <= i_cfg_data;
            end
        end
    end

    `include "assert_macros.svh"

    `BSDE_ASSERT(a_emit_returns_idle, i_clk, i_rst_n, (r_state == S_EMIT) |=> (r_state == S_IDLE), "emit not followed by idle")
    `BSDE_NEVER(a_no_store_write_busy, i_clk, i_rst_n, busy && (o_cmd.wr_knot || o_cmd.wr_point || o_cmd.latch), "store write or latch while busy")
    `BSDE_ASSERT(a_degree_held, i_clk, i_rst_n, (busy && $past(busy)) |-> $stable(r_deg), "degree changed during evaluation")
    `BSDE_NEVER(a_level_order, i_clk, i_rst_n, (r_state == S_KA) && ((r_j < r_r) || (r_r == '0) || (r_j > p_eff)), "level indices out of order")
endmodule
